// File: hw/rtl/assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FRR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FRR_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FRR_ASSERT(name, clk, rst_n, prop, msg)

`define FRR_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: hw/rtl/frr_pkg.sv
package frr_pkg;

    localparam int FRAME_MAX = 198;
    localparam int HDR_BYTES = 3;
    localparam int BUF_BYTES = 4096;

    localparam int FILL_W = 13;
    localparam int PAY_W  = 8;
    localparam int ADDR_W = 4;

    localparam logic [2:0] OP_FIRST = 3'd0;
    localparam logic [2:0] OP_MID   = 3'd1;
    localparam logic [2:0] OP_LAST  = 3'd2;
    localparam logic [2:0] OP_ABORT = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;

    localparam logic [1:0] PH_FREE = 2'd0;
    localparam logic [1:0] PH_RECV = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_ACK   = 2'd1;
    localparam logic [1:0] K_ABORT = 2'd2;
    localparam logic [1:0] K_ERROR = 2'd3;

    localparam logic [1:0] REG_DEST_A   = 2'd0;
    localparam logic [1:0] REG_DEST_B   = 2'd1;
    localparam logic [1:0] REG_IDLE_TO  = 2'd2;
    localparam logic [1:0] REG_MAX_TIME = 2'd3;

    localparam logic [7:0]  DEST_A_RST   = 8'd0;
    localparam logic [7:0]  DEST_B_RST   = 8'd1;
    localparam logic [31:0] IDLE_TO_RST  = 32'd5000;
    localparam logic [31:0] MAX_TIME_RST = 32'd60000;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [7:0]  session_id;
        logic [15:0] seq_num;
        logic [15:0] frame_len;
        logic [7:0]  dest_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  reply_kind;
        logic [7:0]  reply_session;
        logic [15:0] reply_seq;
        logic [7:0]  reply_dest;
        logic        write_enable;
        logic [11:0] write_offset;
        logic [7:0]  write_length;
        logic        assembly_done;
        logic [12:0] total_length;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  allowed_dest_a;
        logic [7:0]  allowed_dest_b;
        logic [31:0] idle_timeout;
        logic [31:0] max_transfer_time;
    } t_cfg;

endpackage

// File: hw/rtl/frr_engine.sv
`include "assert_macros.svh"

module frr_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  frr_pkg::t_in_item  i_item,
    input  frr_pkg::t_cfg      i_cfg,
    output frr_pkg::t_out_item o_result
);

    logic [1:0]                  r_phase, n_phase;
    logic [7:0]                  r_cur_session, n_cur_session;
    logic [15:0]                 r_last_seq, n_last_seq;
    logic [frr_pkg::FILL_W-1:0]  r_fill_bytes, n_fill_bytes;
    logic [7:0]                  r_session_dest, n_session_dest;
    logic                        r_timer_active, n_timer_active;
    logic [31:0]                 r_since_activity, n_since_activity;
    logic [31:0]                 r_since_start, n_since_start;

    logic                        dest_ok;
    logic                        len_ok;
    logic                        last_size_ok;
    logic [frr_pkg::PAY_W-1:0]   payload;
    logic [frr_pkg::FILL_W:0]    fill_sum;
    logic                        fill_over;
    logic                        seq_far;
    logic [31:0]                 act_inc;
    logic [31:0]                 start_inc;
    logic                        is_last;
    logic                        phase_ok;
    logic                        size_ok;
    frr_pkg::t_out_item          res;

    assign dest_ok = (i_item.dest_id == i_cfg.allowed_dest_a) ||
                     (i_item.dest_id == i_cfg.allowed_dest_b);
    assign len_ok = (i_item.frame_len >= 16'(frr_pkg::HDR_BYTES)) &&
                    (i_item.frame_len <= 16'(frr_pkg::FRAME_MAX));
    assign last_size_ok = (i_item.frame_len > 16'(frr_pkg::HDR_BYTES)) &&
                          (i_item.frame_len <= 16'(frr_pkg::FRAME_MAX));
    assign payload = len_ok ? frr_pkg::PAY_W'(i_item.frame_len - 16'(frr_pkg::HDR_BYTES))
                            : '0;
    assign fill_sum = {1'b0, r_fill_bytes} + (frr_pkg::FILL_W + 1)'(payload);
    assign fill_over = fill_sum > (frr_pkg::FILL_W + 1)'(frr_pkg::BUF_BYTES);
    assign seq_far = {1'b0, i_item.seq_num} > ({1'b0, r_last_seq} + 17'd1);
    assign act_inc = (r_since_activity == '1) ? r_since_activity : r_since_activity + 32'd1;
    assign start_inc = (r_since_start == '1) ? r_since_start : r_since_start + 32'd1;
    assign is_last = (i_item.opcode == frr_pkg::OP_LAST);
    assign phase_ok = is_last ? ((r_phase == frr_pkg::PH_RECV) ||
                                 (r_phase == frr_pkg::PH_DONE))
                              : (r_phase == frr_pkg::PH_RECV);
    assign size_ok = is_last ? last_size_ok : len_ok;

    always_comb begin
        n_phase          = r_phase;
        n_cur_session    = r_cur_session;
        n_last_seq       = r_last_seq;
        n_fill_bytes     = r_fill_bytes;
        n_session_dest   = r_session_dest;
        n_timer_active   = r_timer_active;
        n_since_activity = r_since_activity;
        n_since_start    = r_since_start;
        res              = '0;

        unique case (i_item.opcode)
            frr_pkg::OP_FIRST: begin
                if (r_phase == frr_pkg::PH_DONE) begin
                    n_phase          = frr_pkg::PH_FREE;
                    n_last_seq       = '0;
                    n_timer_active   = 1'b0;
                    n_since_activity = '0;
                    n_since_start    = '0;
                end
                if (!dest_ok || !len_ok) begin
                    res.reply_kind = frr_pkg::K_ERROR;
                end else if (r_phase == frr_pkg::PH_RECV && r_last_seq == i_item.seq_num &&
                             r_cur_session == i_item.session_id) begin
                    res.reply_kind    = frr_pkg::K_ACK;
                    res.reply_session = r_cur_session;
                    res.reply_seq     = r_last_seq;
                    res.reply_dest    = i_item.dest_id;
                end else if (r_phase == frr_pkg::PH_RECV) begin
                    res.reply_kind    = frr_pkg::K_ABORT;
                    res.reply_session = i_item.session_id;
                    res.reply_dest    = i_item.dest_id;
                end else begin
                    n_last_seq       = i_item.seq_num;
                    n_fill_bytes     = frr_pkg::FILL_W'(payload);
                    n_cur_session    = i_item.session_id;
                    n_session_dest   = i_item.dest_id;
                    n_phase          = frr_pkg::PH_RECV;
                    n_timer_active   = 1'b1;
                    n_since_activity = '0;
                    n_since_start    = '0;
                    res.write_enable = (payload != '0);
                    res.write_length = payload;
                    res.reply_kind    = frr_pkg::K_ACK;
                    res.reply_session = i_item.session_id;
                    res.reply_seq     = i_item.seq_num;
                    res.reply_dest    = i_item.dest_id;
                end
            end
            frr_pkg::OP_MID, frr_pkg::OP_LAST: begin
                if (!phase_ok) begin
                    res.reply_kind = frr_pkg::K_ERROR;
                end else if (i_item.session_id != r_cur_session) begin
                    res.reply_kind    = frr_pkg::K_ABORT;
                    res.reply_session = i_item.session_id;
                    res.reply_dest    = i_item.dest_id;
                end else if (!dest_ok || seq_far || !size_ok) begin
                    res.reply_kind = frr_pkg::K_ERROR;
                end else if ((!is_last && i_item.seq_num == r_last_seq) ||
                             (is_last && r_phase == frr_pkg::PH_DONE)) begin
                    res.reply_kind    = frr_pkg::K_ACK;
                    res.reply_session = r_cur_session;
                    res.reply_seq     = r_last_seq;
                    res.reply_dest    = i_item.dest_id;
                end else if (fill_over) begin
                    res.reply_kind = frr_pkg::K_ERROR;
                end else begin
                    if (payload != '0) begin
                        res.write_enable = 1'b1;
                        res.write_offset = r_fill_bytes[11:0];
                        res.write_length = payload;
                    end
                    n_last_seq        = i_item.seq_num;
                    n_fill_bytes      = fill_sum[frr_pkg::FILL_W-1:0];
                    res.reply_kind    = frr_pkg::K_ACK;
                    res.reply_session = r_cur_session;
                    res.reply_seq     = i_item.seq_num;
                    res.reply_dest    = i_item.dest_id;
                    if (is_last) begin
                        n_phase           = frr_pkg::PH_DONE;
                        res.assembly_done = 1'b1;
                        res.total_length  = fill_sum[12:0];
                    end else begin
                        n_since_activity = '0;
                    end
                end
            end
            frr_pkg::OP_ABORT: begin
                n_phase          = frr_pkg::PH_FREE;
                n_last_seq       = '0;
                n_timer_active   = 1'b0;
                n_since_activity = '0;
                n_since_start    = '0;
            end
            frr_pkg::OP_TICK: begin
                if (r_timer_active) begin
                    n_since_activity = act_inc;
                    n_since_start    = start_inc;
                    if (act_inc > i_cfg.idle_timeout ||
                        start_inc > i_cfg.max_transfer_time) begin
                        if (r_phase == frr_pkg::PH_RECV) begin
                            res.reply_kind    = frr_pkg::K_ABORT;
                            res.reply_session = r_cur_session;
                            res.reply_dest    = r_session_dest;
                        end
                        n_phase          = frr_pkg::PH_FREE;
                        n_last_seq       = '0;
                        n_timer_active   = 1'b0;
                        n_since_activity = '0;
                        n_since_start    = '0;
                    end
                end
            end
            default: begin
                res.reply_kind = frr_pkg::K_ERROR;
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= frr_pkg::PH_FREE;
            r_cur_session    <= '0;
            r_last_seq       <= '0;
            r_fill_bytes     <= '0;
            r_session_dest   <= '0;
            r_timer_active   <= 1'b0;
            r_since_activity <= '0;
            r_since_start    <= '0;
        end else if (i_accept) begin
            r_phase          <= n_phase;
            r_cur_session    <= n_cur_session;
            r_last_seq       <= n_last_seq;
            r_fill_bytes     <= n_fill_bytes;
            r_session_dest   <= n_session_dest;
            r_timer_active   <= n_timer_active;
            r_since_activity <= n_since_activity;
            r_since_start    <= n_since_start;
        end
    end

    `FRR_ASSERT(a_we_needs_ack, i_clk, i_rst_n,
        i_accept && res.write_enable |-> res.reply_kind == frr_pkg::K_ACK,
        "payload store without ack")
    `FRR_ASSERT(a_done_phase, i_clk, i_rst_n,
        i_accept && res.assembly_done |=> r_phase == frr_pkg::PH_DONE,
        "completion without done phase")
    `FRR_ASSERT(a_fill_bound, i_clk, i_rst_n,
        r_fill_bytes <= frr_pkg::FILL_W'(frr_pkg::BUF_BYTES),
        "fill beyond buffer")
    `FRR_ASSERT(a_idle_timers, i_clk, i_rst_n,
        !r_timer_active |-> r_since_activity == '0 && r_since_start == '0,
        "counters running with timer off")

endmodule

// File: hw/rtl/fragment_reassembly_receiver.sv
// the result is registered: an accepted transfer is offered as a result in the next cycle
// throughput: one item per cycle while the input does not stall, set by the single registered decision stage
// input stalls only while the result register holds an untaken result and the output stalls
// reset (synchronous, active low) frees the session, zeroes the counters and the fill,
// and loads the configuration registers with their defaults
module fragment_reassembly_receiver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  frr_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output frr_pkg::t_out_item         o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [frr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic               accept;
    logic               cfg_write;
    logic [1:0]         reg_sel;
    frr_pkg::t_cfg      cfg;
    frr_pkg::t_out_item result;

    logic               r_out_valid;
    frr_pkg::t_out_item r_out_data;
    logic [7:0]         r_dest_a;
    logic [7:0]         r_dest_b;
    logic [31:0]        r_idle_timeout;
    logic [31:0]        r_max_time;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_a       <= frr_pkg::DEST_A_RST;
            r_dest_b       <= frr_pkg::DEST_B_RST;
            r_idle_timeout <= frr_pkg::IDLE_TO_RST;
            r_max_time     <= frr_pkg::MAX_TIME_RST;
        end else if (cfg_write) begin
            unique case (reg_sel)
                frr_pkg::REG_DEST_A:   r_dest_a       <= pwdata[7:0];
                frr_pkg::REG_DEST_B:   r_dest_b       <= pwdata[7:0];
                frr_pkg::REG_IDLE_TO:  r_idle_timeout <= pwdata;
                frr_pkg::REG_MAX_TIME: r_max_time     <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            frr_pkg::REG_DEST_A:   prdata = {24'd0, r_dest_a};
            frr_pkg::REG_DEST_B:   prdata = {24'd0, r_dest_b};
            frr_pkg::REG_IDLE_TO:  prdata = r_idle_timeout;
            frr_pkg::REG_MAX_TIME: prdata = r_max_time;
        endcase
    end

    assign cfg.allowed_dest_a    = r_dest_a;
    assign cfg.allowed_dest_b    = r_dest_b;
    assign cfg.idle_timeout      = r_idle_timeout;
    assign cfg.max_transfer_time = r_max_time;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    frr_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // result register, refilled in the same cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [2:0] OP_INVALID_LO = 3'd5;
    localparam logic [2:0] OP_INVALID_HI = 3'd7;
    localparam int NO_ACTIVITY_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_GAP = 30;
    localparam int MAX_REPORTS = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    frr_pkg::t_in_item  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    frr_pkg::t_out_item o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [frr_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // shadow of the configuration registers
    logic [7:0]  dest_a = frr_pkg::DEST_A_RST;
    logic [7:0]  dest_b = frr_pkg::DEST_B_RST;
    logic [31:0] idle_limit = frr_pkg::IDLE_TO_RST;
    logic [31:0] run_limit = frr_pkg::MAX_TIME_RST;

    // shadow of the session state
    logic [1:0]  rx_phase = frr_pkg::PH_FREE;
    logic [7:0]  rx_session = '0;
    logic [15:0] rx_last_seq = '0;
    logic [12:0] rx_fill = '0;
    logic [7:0]  rx_dest = '0;
    logic        timers_on = 1'b0;
    logic [31:0] idle_ticks = '0;
    logic [31:0] run_ticks = '0;

    frr_pkg::t_out_item pending_replies[$];

    int items_sent = 0;
    int replies_checked = 0;
    int mismatches = 0;
    int reassemblies = 0;
    int timer_aborts = 0;
    int overflow_rejects = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    fragment_reassembly_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void drop_session();
        rx_phase = frr_pkg::PH_FREE;
        rx_last_seq = '0;
        timers_on = 1'b0;
        idle_ticks = '0;
        run_ticks = '0;
    endfunction

    function automatic frr_pkg::t_out_item predict_reply(input frr_pkg::t_in_item it);
        frr_pkg::t_out_item r;
        logic dest_ok;
        logic len_ok;
        logic size_ok;
        logic phase_ok;
        logic is_last;
        int pay;
        r = '0;
        dest_ok = (it.dest_id == dest_a) || (it.dest_id == dest_b);
        len_ok = (it.frame_len >= frr_pkg::HDR_BYTES) && (it.frame_len <= frr_pkg::FRAME_MAX);
        pay = len_ok ? int'(it.frame_len) - frr_pkg::HDR_BYTES : 0;
        case (it.opcode)
            frr_pkg::OP_FIRST: begin
                if (rx_phase == frr_pkg::PH_DONE) drop_session();
                if (!dest_ok || !len_ok) begin
                    r.reply_kind = frr_pkg::K_ERROR;
                end else if (rx_phase == frr_pkg::PH_RECV && rx_last_seq == it.seq_num &&
                             rx_session == it.session_id) begin
                    r.reply_kind = frr_pkg::K_ACK;
                    r.reply_session = rx_session;
                    r.reply_seq = rx_last_seq;
                    r.reply_dest = it.dest_id;
                end else if (rx_phase != frr_pkg::PH_FREE) begin
                    r.reply_kind = frr_pkg::K_ABORT;
                    r.reply_session = it.session_id;
                    r.reply_dest = it.dest_id;
                end else begin
                    rx_last_seq = it.seq_num;
                    rx_fill = 13'(pay);
                    rx_session = it.session_id;
                    rx_dest = it.dest_id;
                    rx_phase = frr_pkg::PH_RECV;
                    timers_on = 1'b1;
                    idle_ticks = '0;
                    run_ticks = '0;
                    if (pay != 0) begin
                        r.write_enable = 1'b1;
                        r.write_length = 8'(pay);
                    end
                    r.reply_kind = frr_pkg::K_ACK;
                    r.reply_session = rx_session;
                    r.reply_seq = rx_last_seq;
                    r.reply_dest = it.dest_id;
                end
            end
            frr_pkg::OP_MID, frr_pkg::OP_LAST: begin
                is_last = (it.opcode == frr_pkg::OP_LAST);
                phase_ok = is_last ? (rx_phase == frr_pkg::PH_RECV ||
                                      rx_phase == frr_pkg::PH_DONE)
                                   : (rx_phase == frr_pkg::PH_RECV);
                size_ok = is_last ? (it.frame_len > frr_pkg::HDR_BYTES &&
                                     it.frame_len <= frr_pkg::FRAME_MAX)
                                  : len_ok;
                if (!phase_ok) begin
                    r.reply_kind = frr_pkg::K_ERROR;
                end else if (it.session_id != rx_session) begin
                    r.reply_kind = frr_pkg::K_ABORT;
                    r.reply_session = it.session_id;
                    r.reply_dest = it.dest_id;
                end else if (!dest_ok || int'(it.seq_num) > int'(rx_last_seq) + 1 ||
                             !size_ok) begin
                    r.reply_kind = frr_pkg::K_ERROR;
                end else if ((!is_last && it.seq_num == rx_last_seq) ||
                             (is_last && rx_phase == frr_pkg::PH_DONE)) begin
                    r.reply_kind = frr_pkg::K_ACK;
                    r.reply_session = rx_session;
                    r.reply_seq = rx_last_seq;
                    r.reply_dest = it.dest_id;
                end else if (int'(rx_fill) + pay > frr_pkg::BUF_BYTES) begin
                    r.reply_kind = frr_pkg::K_ERROR;
                    overflow_rejects++;
                end else begin
                    if (pay != 0) begin
                        r.write_enable = 1'b1;
                        r.write_offset = rx_fill[11:0];
                        r.write_length = 8'(pay);
                    end
                    rx_last_seq = it.seq_num;
                    rx_fill = rx_fill + 13'(pay);
                    r.reply_kind = frr_pkg::K_ACK;
                    r.reply_session = rx_session;
                    r.reply_seq = rx_last_seq;
                    r.reply_dest = it.dest_id;
                    if (is_last) begin
                        rx_phase = frr_pkg::PH_DONE;
                        r.assembly_done = 1'b1;
                        r.total_length = rx_fill;
                        reassemblies++;
                    end else begin
                        idle_ticks = '0;
                    end
                end
            end
            frr_pkg::OP_ABORT: begin
                drop_session();
            end
            frr_pkg::OP_TICK: begin
                if (timers_on) begin
                    if (idle_ticks != '1) idle_ticks = idle_ticks + 1;
                    if (run_ticks != '1) run_ticks = run_ticks + 1;
                    if (idle_ticks > idle_limit || run_ticks > run_limit) begin
                        if (rx_phase == frr_pkg::PH_RECV) begin
                            r.reply_kind = frr_pkg::K_ABORT;
                            r.reply_session = rx_session;
                            r.reply_dest = rx_dest;
                            timer_aborts++;
                        end
                        drop_session();
                    end
                end
            end
            default: begin
                r.reply_kind = frr_pkg::K_ERROR;
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // reply checker and reply prediction, both sampled at the rising edge
    always @(posedge i_clk) begin
        frr_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected reply, expected none, actual %h",
                                 $time, o_out_data);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("reply_kind", want.reply_kind, o_out_data.reply_kind);
                    check_field("reply_session", want.reply_session,
                                o_out_data.reply_session);
                    check_field("reply_seq", want.reply_seq, o_out_data.reply_seq);
                    check_field("reply_dest", want.reply_dest, o_out_data.reply_dest);
                    check_field("write_enable", want.write_enable, o_out_data.write_enable);
                    check_field("write_offset", want.write_offset, o_out_data.write_offset);
                    check_field("write_length", want.write_length, o_out_data.write_length);
                    check_field("assembly_done", want.assembly_done,
                                o_out_data.assembly_done);
                    check_field("total_length", want.total_length, o_out_data.total_length);
                    replies_checked++;
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_replies.push_back(predict_reply(i_in_data));
        end
    end

    // output side back-pressure, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= NO_ACTIVITY_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d replies outstanding",
                         $time, quiet_cycles, pending_replies.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic frr_pkg::t_in_item make_frame(input logic [2:0] op,
                                                     input logic [7:0] sid,
                                                     input logic [15:0] seq,
                                                     input logic [15:0] len,
                                                     input logic [7:0] dst);
        frr_pkg::t_in_item f;
        f.opcode = op;
        f.session_id = sid;
        f.seq_num = seq;
        f.frame_len = len;
        f.dest_id = dst;
        return f;
    endfunction

    function automatic frr_pkg::t_in_item random_frame(input logic [2:0] op);
        return make_frame(op, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endfunction

    function automatic logic [15:0] pick_len(input bit big);
        int roll;
        roll = $urandom_range(0, 99);
        if (big) return 16'($urandom_range(150, frr_pkg::FRAME_MAX));
        if (roll < 4) return 16'($urandom_range(0, 65535));
        if (roll < 8) return 16'($urandom_range(0, frr_pkg::HDR_BYTES));
        if (roll < 10) return 16'(frr_pkg::FRAME_MAX + 1);
        return 16'($urandom_range(frr_pkg::HDR_BYTES + 1, frr_pkg::FRAME_MAX));
    endfunction

    function automatic logic [7:0] pick_dest();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 46) return dest_a;
        if (roll < 92) return dest_b;
        return 8'($urandom);
    endfunction

    task automatic send_frame(input frr_pkg::t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            frr_pkg::REG_DEST_A: dest_a = val[7:0];
            frr_pkg::REG_DEST_B: dest_b = val[7:0];
            frr_pkg::REG_IDLE_TO: idle_limit = val;
            frr_pkg::REG_MAX_TIME: run_limit = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] a, input logic [7:0] b,
                              input logic [31:0] idle_to, input logic [31:0] max_time);
        write_reg(frr_pkg::REG_DEST_A, {24'd0, a});
        write_reg(frr_pkg::REG_DEST_B, {24'd0, b});
        write_reg(frr_pkg::REG_IDLE_TO, idle_to);
        write_reg(frr_pkg::REG_MAX_TIME, max_time);
    endtask

    // reset defaults: destinations 0 and 1
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct = 0;
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'd5, 16'd10, 16'd3, 8'd0));
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'd5, 16'd10, 16'd50, 8'd1));
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'd6, 16'd0, 16'd50, 8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd5, 16'd10, 16'd20, 8'd0));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd5, 16'd12, 16'd20, 8'd0));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd7, 16'd11, 16'd20, 8'd0));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd5, 16'd11, 16'(frr_pkg::FRAME_MAX), 8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd5, 16'd12, 16'(frr_pkg::FRAME_MAX + 1),
                              8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd5, 16'd12, 16'd2, 8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd5, 16'd12, 16'd20, 8'hFF));
        send_frame(make_frame(frr_pkg::OP_LAST, 8'd5, 16'd12, 16'(frr_pkg::HDR_BYTES), 8'd0));
        send_frame(make_frame(frr_pkg::OP_LAST, 8'd5, 16'd12, 16'd4, 8'd0));
        send_frame(make_frame(frr_pkg::OP_LAST, 8'd5, 16'd12, 16'd4, 8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'd5, 16'd13, 16'd4, 8'd1));
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'hFF, 16'hFFFF, 16'(frr_pkg::FRAME_MAX),
                              8'd0));
        send_frame(make_frame(frr_pkg::OP_ABORT, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_frame(make_frame(frr_pkg::OP_MID, 8'hFF, 16'd0, 16'd10, 8'd0));
        for (int op = OP_INVALID_LO; op <= OP_INVALID_HI; op++)
            send_frame(random_frame(3'(op)));
        send_frame(random_frame(frr_pkg::OP_TICK));
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'd1, 16'd1, 16'hFFFF, 8'd0));
        // fill the buffer to the last byte, then overrun it
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h80, 16'd100, 16'(frr_pkg::FRAME_MAX),
                              8'd1));
        for (int k = 1; k <= 20; k++)
            send_frame(make_frame(frr_pkg::OP_MID, 8'h80, 16'(100 + k),
                                  16'(frr_pkg::FRAME_MAX), 8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'h80, 16'd121, 16'd5, 8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'h80, 16'd121, 16'd4, 8'd1));
        send_frame(make_frame(frr_pkg::OP_MID, 8'h80, 16'd122, 16'(frr_pkg::HDR_BYTES), 8'd0));
        send_frame(make_frame(frr_pkg::OP_LAST, 8'h80, 16'd123, 16'd4, 8'd0));
        send_frame(make_frame(frr_pkg::OP_ABORT, 8'd0, 16'd0, 16'd0, 8'd0));
    endtask

    task automatic test_timeouts();
        set_config(8'h00, 8'hFF, 32'd2, 32'hFFFF_FFFF);
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h11, 16'd0, 16'd10, 8'hFF));
        repeat (2) send_frame(random_frame(frr_pkg::OP_TICK));
        send_frame(make_frame(frr_pkg::OP_MID, 8'h11, 16'd1, 16'd10, 8'h00));
        repeat (4) send_frame(random_frame(frr_pkg::OP_TICK));
        set_config(8'hFF, 8'h00, 32'hFFFF_FFFF, 32'd3);
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h22, 16'd5, 16'd3, 8'h00));
        send_frame(make_frame(frr_pkg::OP_MID, 8'h22, 16'd6, 16'd9, 8'hFF));
        repeat (4) send_frame(random_frame(frr_pkg::OP_TICK));
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h23, 16'd0, 16'd9, 8'h00));
        send_frame(make_frame(frr_pkg::OP_LAST, 8'h23, 16'd1, 16'd9, 8'h00));
        repeat (4) send_frame(random_frame(frr_pkg::OP_TICK));
        set_config(8'h00, 8'h00, 32'd0, 32'd0);
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h44, 16'd7, 16'd8, 8'h00));
        send_frame(random_frame(frr_pkg::OP_TICK));
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h45, 16'd7, 16'd8, 8'h00));
        send_frame(make_frame(frr_pkg::OP_LAST, 8'h45, 16'd8, 16'd8, 8'h00));
        send_frame(random_frame(frr_pkg::OP_TICK));
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h46, 16'd0, 16'd8, 8'h00));
        send_frame(make_frame(frr_pkg::OP_ABORT, 8'h46, 16'd0, 16'd0, 8'h00));
    endtask

    task automatic test_random_traffic(input logic [7:0] a, input logic [7:0] b,
                                       input logic [31:0] idle_to, input logic [31:0] max_time,
                                       input int idle_pct, input int stall_mix, input int n_items);
        int start;
        int n_mid;
        int roll;
        bit big;
        logic [7:0] sid;
        logic [15:0] seq;
        logic [15:0] nxt;
        set_config(a, b, idle_to, max_time);
        send_idle_pct = idle_pct;
        stall_pct = stall_mix;
        start = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(0, 99) < 12) begin
                send_frame(random_frame(3'($urandom_range(0, 7))));
            end else begin
                sid = 8'($urandom);
                seq = ($urandom_range(0, 7) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                                  : 16'($urandom);
                big = ($urandom_range(0, 7) == 0);
                n_mid = big ? $urandom_range(18, 26) : $urandom_range(0, 6);
                send_frame(make_frame(frr_pkg::OP_FIRST, sid, seq, pick_len(1'b0),
                                      pick_dest()));
                for (int k = 0; k <= n_mid; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8) send_frame(random_frame(frr_pkg::OP_TICK));
                    else if (roll < 10) send_frame(random_frame(frr_pkg::OP_ABORT));
                    nxt = seq + 16'd1;
                    if (roll >= 10 && roll < 14) nxt = seq;
                    else if (roll >= 14 && roll < 17) nxt = seq + 16'd2;
                    send_frame(make_frame((k == n_mid) ? frr_pkg::OP_LAST : frr_pkg::OP_MID,
                                          (roll >= 17 && roll < 20) ? sid ^ 8'h01 : sid,
                                          nxt, pick_len(big), pick_dest()));
                    if (roll >= 17) seq = nxt;
                end
                if ($urandom_range(0, 4) == 0)
                    send_frame(make_frame(frr_pkg::OP_LAST, sid, seq, pick_len(1'b0),
                                          pick_dest()));
                repeat ($urandom_range(0, 2)) send_frame(random_frame(frr_pkg::OP_TICK));
            end
        end
    endtask

    // output held off while frames keep coming, so the input side must stall
    task automatic test_backpressure();
        set_config(8'h10, 8'h20, 32'd1000, 32'd100000);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
        send_frame(make_frame(frr_pkg::OP_FIRST, 8'h3C, 16'd0, 16'd40, 8'h10));
        for (int k = 1; k <= 40; k++)
            send_frame(make_frame((k == 40) ? frr_pkg::OP_LAST : frr_pkg::OP_MID, 8'h3C,
                                  16'(k),
                                  16'($urandom_range(frr_pkg::HDR_BYTES + 1, 100)), 8'h20));
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_timeouts();
        test_random_traffic(8'h00, 8'hFF, 32'd40, 32'd300, 0, 0, 350);
        test_random_traffic(8'h5A, 8'hA5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 68, 0, 350);
        test_random_traffic(8'h33, 8'h33, 32'd0, 32'd0, 0, 68, 350);
        test_random_traffic(8'hFF, 8'h00, 32'd7, 32'd25, 37, 37, 350);
        test_backpressure();
        drain();
        repeat (8) @(posedge i_clk);
        $display("%0d items: directed frames, timer limits, random sessions and a long hold-off",
                 items_sent);
        $display("%0d replies checked, %0d reassemblies, %0d timer aborts, %0d overflow rejects",
                 replies_checked, reassemblies, timer_aborts, overflow_rejects);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
